// File: sv/prs_pkg.sv
// Shared types and codes for the process ring scheduler.
// No dependencies; used by prs_ctrl, prs_dp and process_ring_scheduler.
`default_nettype none

package prs_pkg;

    // request codes
    localparam logic [2:0] REQ_APPEND = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_NEXT   = 3'd2;
    localparam logic [2:0] REQ_FIND   = 3'd3;
    localparam logic [2:0] REQ_SETRDY = 3'd4;

    // read address source for the ring memories
    localparam logic [1:0] RD_SLOT = 2'd0;
    localparam logic [1:0] RD_HEAD = 2'd1;
    localparam logic [1:0] RD_WALK = 2'd2;

    // result register load select
    localparam logic [2:0] OUT_HOLD = 3'd0;
    localparam logic [2:0] OUT_ERR  = 3'd1;
    localparam logic [2:0] OUT_NONE = 3'd2;
    localparam logic [2:0] OUT_NEXT = 3'd3;
    localparam logic [2:0] OUT_FIND = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  slot;
        logic [31:0] proc_id;
        logic        ready_in;
    } t_req;

    typedef struct packed {
        logic [3:0] result_slot;
        logic       found;
        logic       error;
    } t_result;

    typedef struct packed {
        logic       capture;
        logic [1:0] rd_sel;
        logic       app_first;
        logic       app_link;
        logic       app_head;
        logic       rm_first;
        logic       rm_single;
        logic       rm_unlink;
        logic       set_rdy;
        logic [2:0] out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_ok;
        logic slot_linked;
        logic nonempty;
        logic cap_is_head;
        logic link_eq_s;
        logic link_eq_head;
        logic link_ready;
        logic id_match;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: sv/prs_dp.sv
// Datapath: link and id memories, ready/linked flags, head, walk read pipe
// and result register. Depends on prs_pkg.
`default_nettype none

module prs_dp #(
    parameter int RING_SLOTS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  prs_pkg::t_req        i_req,
    input  prs_pkg::t_dp_cmd     i_cmd,
    output prs_pkg::t_dp_sts     o_sts,
    output prs_pkg::t_result     o_result
);

    localparam int IW = (RING_SLOTS > 2) ? $clog2(RING_SLOTS) : 1;
    localparam logic [8:0] NSLOTS = 9'(RING_SLOTS);

    logic [IW-1:0] r_link_mem [RING_SLOTS];
    logic [31:0]   r_id_mem   [RING_SLOTS];

    logic [RING_SLOTS-1:0] r_ready,    n_ready;
    logic [RING_SLOTS-1:0] r_linked,   n_linked;
    logic [IW-1:0]         r_head,     n_head;
    logic                  r_nonempty, n_nonempty;

    logic [IW-1:0] r_slot;
    logic [31:0]   r_id;
    logic          r_rdy;

    logic [IW-1:0] r_rd_link;
    logic [31:0]   r_rd_id;
    logic          r_rd_lnk;
    logic [IW-1:0] r_rd_addr;
    logic [IW-1:0] r_save;

    prs_pkg::t_result r_out, n_out;

    logic [IW-1:0] in_idx, w_slot, rd_addr, eff;
    logic [31:0]   w_id;
    logic          w_rdy;
    logic          lw_en, iw_en;
    logic [IW-1:0] lw_addr, lw_data, iw_addr;
    logic [31:0]   iw_data;

    assign in_idx = IW'(i_req.slot);
    assign w_slot = i_cmd.capture ? in_idx : r_slot;
    assign w_id   = i_cmd.capture ? i_req.proc_id : r_id;
    assign w_rdy  = i_cmd.capture ? i_req.ready_in : r_rdy;

    // an unlinked slot always points at itself
    assign eff = r_rd_lnk ? r_rd_link : r_rd_addr;

    always_comb begin
        case (i_cmd.rd_sel)
            prs_pkg::RD_SLOT: rd_addr = in_idx;
            prs_pkg::RD_WALK: rd_addr = eff;
            default:          rd_addr = r_head;
        endcase
    end

    // single write port per memory
    always_comb begin
        lw_en   = 1'b0;
        lw_addr = w_slot;
        lw_data = w_slot;
        iw_en   = 1'b0;
        iw_addr = w_slot;
        iw_data = w_id;
        if (i_cmd.app_first) begin
            lw_en = 1'b1;
            iw_en = 1'b1;
        end else if (i_cmd.app_link) begin
            lw_en   = 1'b1;
            lw_data = eff;
            iw_en   = 1'b1;
        end else if (i_cmd.app_head) begin
            lw_en   = 1'b1;
            lw_addr = r_head;
            lw_data = r_slot;
        end else if (i_cmd.rm_unlink) begin
            lw_en   = 1'b1;
            lw_addr = r_rd_addr;
            lw_data = r_save;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lw_en) begin
            r_link_mem[lw_addr] <= lw_data;
        end
        if (iw_en) begin
            r_id_mem[iw_addr] <= iw_data;
        end
        r_rd_link <= r_link_mem[rd_addr];
        r_rd_id   <= r_id_mem[rd_addr];
        r_rd_lnk  <= r_linked[rd_addr];
        r_rd_addr <= rd_addr;
    end

    always_comb begin
        n_ready    = r_ready;
        n_linked   = r_linked;
        n_head     = r_head;
        n_nonempty = r_nonempty;
        if (i_cmd.app_first || i_cmd.app_link || i_cmd.set_rdy) begin
            n_ready[w_slot] = w_rdy;
        end
        if (i_cmd.app_first || i_cmd.app_link) begin
            n_linked[w_slot] = 1'b1;
        end
        if (i_cmd.rm_single || i_cmd.rm_unlink) begin
            n_linked[r_slot] = 1'b0;
        end
        if (i_cmd.app_first) begin
            n_head     = w_slot;
            n_nonempty = 1'b1;
        end
        if (i_cmd.rm_single) begin
            n_nonempty = 1'b0;
        end
        if (i_cmd.rm_first && (r_slot == r_head)) begin
            n_head = eff;
        end
    end

    always_comb begin
        n_out = r_out;
        case (i_cmd.out_sel)
            prs_pkg::OUT_ERR:  n_out = '{result_slot: 4'd0, found: 1'b0, error: 1'b1};
            prs_pkg::OUT_NONE: n_out = '{result_slot: 4'd0, found: 1'b0, error: 1'b0};
            prs_pkg::OUT_NEXT: n_out = '{result_slot: 4'(eff), found: r_ready[eff],
                                         error: 1'b0};
            prs_pkg::OUT_FIND: n_out = '{result_slot: 4'(r_rd_addr), found: 1'b1,
                                         error: 1'b0};
            default:           n_out = r_out;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready    <= '0;
            r_linked   <= '0;
            r_head     <= '0;
            r_nonempty <= 1'b0;
        end else begin
            r_ready    <= n_ready;
            r_linked   <= n_linked;
            r_head     <= n_head;
            r_nonempty <= n_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_slot <= in_idx;
            r_id   <= i_req.proc_id;
            r_rdy  <= i_req.ready_in;
        end
        if (i_cmd.rm_first) begin
            r_save <= eff;
        end
        r_out <= n_out;
    end

    always_comb begin
        o_sts.slot_ok      = ({5'd0, i_req.slot} < NSLOTS);
        o_sts.slot_linked  = o_sts.slot_ok && r_linked[in_idx];
        o_sts.nonempty     = r_nonempty;
        o_sts.cap_is_head  = (r_slot == r_head);
        o_sts.link_eq_s    = (eff == r_slot);
        o_sts.link_eq_head = (eff == r_head);
        o_sts.link_ready   = r_ready[eff];
        o_sts.id_match     = (r_rd_id == r_id);
    end

    assign o_result = r_out;

endmodule

`default_nettype wire

// File: sv/prs_ctrl.sv
// Controller FSM: decodes requests and sequences ring walks in prs_dp.
// Depends on prs_pkg.
`default_nettype none

module prs_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire  [2:0]        i_req_type,
    input  prs_pkg::t_dp_sts  i_sts,
    output prs_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_strobe
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_APP_LINK = 3'd1;
    localparam logic [2:0] S_APP_HEAD = 3'd2;
    localparam logic [2:0] S_RM_FIRST = 3'd3;
    localparam logic [2:0] S_RM_WALK  = 3'd4;
    localparam logic [2:0] S_NX_WALK  = 3'd5;
    localparam logic [2:0] S_FD_WALK  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_strobe;

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel  = prs_pkg::RD_HEAD;
        o_cmd.out_sel = prs_pkg::OUT_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    case (i_req_type)
                        prs_pkg::REQ_APPEND: begin
                            if (!i_sts.slot_ok || i_sts.slot_linked) begin
                                o_cmd.out_sel = prs_pkg::OUT_ERR;
                            end else if (!i_sts.nonempty) begin
                                o_cmd.app_first = 1'b1;
                                o_cmd.out_sel   = prs_pkg::OUT_NONE;
                            end else begin
                                n_state = S_APP_LINK;
                            end
                        end
                        prs_pkg::REQ_REMOVE: begin
                            if (!i_sts.slot_linked) begin
                                o_cmd.out_sel = prs_pkg::OUT_ERR;
                            end else begin
                                o_cmd.rd_sel = prs_pkg::RD_SLOT;
                                n_state      = S_RM_FIRST;
                            end
                        end
                        prs_pkg::REQ_NEXT: begin
                            if (!i_sts.slot_linked) begin
                                o_cmd.out_sel = prs_pkg::OUT_ERR;
                            end else begin
                                o_cmd.rd_sel = prs_pkg::RD_SLOT;
                                n_state      = S_NX_WALK;
                            end
                        end
                        prs_pkg::REQ_FIND: begin
                            if (!i_sts.nonempty) begin
                                o_cmd.out_sel = prs_pkg::OUT_ERR;
                            end else begin
                                n_state = S_FD_WALK;
                            end
                        end
                        prs_pkg::REQ_SETRDY: begin
                            if (!i_sts.slot_linked) begin
                                o_cmd.out_sel = prs_pkg::OUT_ERR;
                            end else begin
                                o_cmd.set_rdy = 1'b1;
                                o_cmd.out_sel = prs_pkg::OUT_NONE;
                            end
                        end
                        default: o_cmd.out_sel = prs_pkg::OUT_ERR;
                    endcase
                end
            end
            S_APP_LINK: begin
                // head's successor is on the read port now
                o_cmd.app_link = 1'b1;
                n_state        = S_APP_HEAD;
            end
            S_APP_HEAD: begin
                o_cmd.app_head = 1'b1;
                o_cmd.out_sel  = prs_pkg::OUT_NONE;
                n_state        = S_IDLE;
            end
            S_RM_FIRST: begin
                if (i_sts.cap_is_head && i_sts.link_eq_s) begin
                    o_cmd.rm_single = 1'b1;
                    o_cmd.out_sel   = prs_pkg::OUT_NONE;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.rm_first = 1'b1;
                    o_cmd.rd_sel   = prs_pkg::RD_WALK;
                    n_state        = S_RM_WALK;
                end
            end
            S_RM_WALK: begin
                if (i_sts.link_eq_s) begin
                    o_cmd.rm_unlink = 1'b1;
                    o_cmd.out_sel   = prs_pkg::OUT_NONE;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.rd_sel = prs_pkg::RD_WALK;
                end
            end
            S_NX_WALK: begin
                if (i_sts.link_ready || i_sts.link_eq_s) begin
                    o_cmd.out_sel = prs_pkg::OUT_NEXT;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_sel = prs_pkg::RD_WALK;
                end
            end
            S_FD_WALK: begin
                if (i_sts.id_match) begin
                    o_cmd.out_sel = prs_pkg::OUT_FIND;
                    n_state       = S_IDLE;
                end else if (i_sts.link_eq_head) begin
                    o_cmd.out_sel = prs_pkg::OUT_NONE;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_sel = prs_pkg::RD_WALK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (o_cmd.out_sel != prs_pkg::OUT_HOLD);
        end
    end

endmodule

`default_nettype wire

// File: sv/process_ring_scheduler.sv
// Process ring scheduler. Set ready and rejected requests are decided in the
// accepting cycle, as is an append to an empty ring; other appends link the
// slot in behind the head. Remove, next ready and find walk the ring through
// the link memory's registered read port. One request at a time; busy is low
// again in the strobe cycle. Synchronous active-low reset empties the ring;
// results cannot be stalled.
`default_nettype none

module process_ring_scheduler #(
    parameter int RING_SLOTS = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  prs_pkg::t_req     i_req,
    output logic              o_strobe,
    output prs_pkg::t_result  o_result
);

    // command / status between the sequencer and the ring datapath
    prs_pkg::t_dp_cmd cmd;
    prs_pkg::t_dp_sts sts;

    // The controller decodes a request in the transfer cycle. Short requests
    // finish there; walks keep one read in flight per cycle, and the next
    // read address is the link just returned, so one link is covered a cycle.
    prs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_strobe   (o_strobe)
    );

    // Datapath: link memory (unlinked slots read as self-linked, so it needs
    // no clearing), id memory (no reset), ready/linked flag vectors, head.
    prs_dp #(
        .RING_SLOTS (RING_SLOTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

`ifndef ASSERT_OFF
    // a result is only shown once the sequencer has gone idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // an accepted request either finishes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted request produced neither busy nor a result");

    // a walk always ends with a result
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("walk ended without a result");

    // error results carry no slot and no found flag
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.error) |-> (o_result.result_slot == 4'd0 && !o_result.found))
        else $error("error result with slot or found set");
`endif

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for process_ring_scheduler: directed ring cases, then
// random request mixes under several sender idle rates. Depends on prs_pkg.
// A predictor tracks the slot ring and queues one expected result per transfer.

module tb_top;
    import prs_pkg::*;

    localparam int SLOTS        = 16;
    localparam int CYCLE_LIMIT  = 400000;
    // settle time after the last result: longest walk plus a margin
    localparam int DRAIN_CYCLES = SLOTS + 8;

    // request codes with no operation behind them
    localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
    localparam logic [2:0] REQ_BAD_LAST  = 3'd7;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_req    i_req   = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    always #10 i_clk = ~i_clk;

    process_ring_scheduler #(
        .RING_SLOTS(SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // ------------------------------------------------------------------
    // Ring predictor state (mirrors the block after reset)
    // ------------------------------------------------------------------
    logic [3:0]  ring_link [SLOTS];
    logic [31:0] owner_id  [SLOTS];
    logic        is_ready  [SLOTS];
    logic        in_ring   [SLOTS];
    logic [3:0]  ring_head;
    logic        ring_live;

    t_result pending_results[$];
    t_result want;
    int      fail_count  = 0;
    int      cycle_count = 0;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            ring_link[i] = 4'(i);
            owner_id[i]  = '0;
            is_ready[i]  = 1'b0;
            in_ring[i]   = 1'b0;
        end
        ring_head = '0;
        ring_live = 1'b0;
    end

    // Applies one request to the predictor and returns the result it must give.
    function automatic t_result predict_ring_op(input t_req r);
        t_result    res;
        logic [3:0] s;
        logic [3:0] n;
        logic       err;
        logic       stop;
        res  = '0;
        err  = 1'b0;
        stop = 1'b0;
        s    = r.slot;
        case (r.req_type)
            REQ_APPEND: begin
                if (in_ring[s]) begin
                    err = 1'b1;
                end else begin
                    owner_id[s] = r.proc_id;
                    is_ready[s] = r.ready_in;
                    in_ring[s]  = 1'b1;
                    if (!ring_live) begin
                        // empty ring: slot becomes the head, linked to itself
                        ring_head    = s;
                        ring_link[s] = s;
                        ring_live    = 1'b1;
                    end else begin
                        // splice in just after the head
                        ring_link[s]         = ring_link[ring_head];
                        ring_link[ring_head] = s;
                    end
                end
            end
            REQ_REMOVE: begin
                if (!in_ring[s] || !ring_live) begin
                    err = 1'b1;
                end else begin
                    if (s == ring_head) begin
                        if (ring_link[s] == s) begin
                            // last slot leaves: ring goes empty
                            ring_live = 1'b0;
                            in_ring[s] = 1'b0;
                            stop = 1'b1;
                        end else begin
                            ring_head = ring_link[s];
                        end
                    end
                    if (!stop) begin
                        // walk to the predecessor and bypass the slot
                        n = s;
                        for (int i = 0; i < SLOTS && ring_link[n] != s; i++)
                            n = ring_link[n];
                        ring_link[n] = ring_link[s];
                        ring_link[s] = s;
                        in_ring[s]   = 1'b0;
                    end
                end
            end
            REQ_NEXT: begin
                if (!in_ring[s]) begin
                    err = 1'b1;
                end else begin
                    // first ready slot after s; back at s when none other is ready
                    n = ring_link[s];
                    for (int i = 0; i < SLOTS && !(is_ready[n] || n == s); i++)
                        n = ring_link[n];
                    res.result_slot = n;
                    res.found       = is_ready[n];
                end
            end
            REQ_FIND: begin
                if (!ring_live) begin
                    err = 1'b1;
                end else begin
                    // head first, once around; first match wins
                    n = ring_head;
                    for (int i = 0; i < SLOTS && !stop; i++) begin
                        if (owner_id[n] == r.proc_id) begin
                            res.result_slot = n;
                            res.found       = 1'b1;
                            stop            = 1'b1;
                        end else begin
                            n = ring_link[n];
                            if (n == ring_head)
                                stop = 1'b1;
                        end
                    end
                end
            end
            REQ_SETRDY: begin
                if (!in_ring[s])
                    err = 1'b1;
                else
                    is_ready[s] = r.ready_in;
            end
            default: err = 1'b1;
        endcase
        if (err) begin
            res       = '0;
            res.error = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe is one transfer, compared with the oldest
    // pending prediction. The receiver side cannot stall.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual slot=%0d found=%0b error=%0b",
                         $time, o_result.result_slot, o_result.found, o_result.error);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.result_slot !== want.result_slot) begin
                    $display("%0t: result_slot mismatch: expected %0d actual %0d",
                             $time, want.result_slot, o_result.result_slot);
                    fail_count++;
                end
                if (o_result.found !== want.found) begin
                    $display("%0t: found mismatch: expected %0b actual %0b",
                             $time, want.found, o_result.found);
                    fail_count++;
                end
                if (o_result.error !== want.error) begin
                    $display("%0t: error mismatch: expected %0b actual %0b",
                             $time, want.error, o_result.error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // One transfer: optional idle cycles first, then start held until the
    // block takes the request (start high, busy low at the edge).
    task automatic send_req(input t_req r, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(predict_ring_op(r));
    endtask

    // Stop sending and let every outstanding result arrive.
    task automatic wait_all_done();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_req mk_req(input logic [2:0] op, input logic [3:0] slot,
                                    input logic [31:0] id, input logic rdy);
        t_req r;
        r.req_type = op;
        r.slot     = slot;
        r.proc_id  = id;
        r.ready_in = rdy;
        return r;
    endfunction

    // Random slot, linked or free as asked; any slot if none qualifies.
    function automatic logic [3:0] pick_slot(input logic want_linked);
        logic [3:0] cands[$];
        for (int i = 0; i < SLOTS; i++)
            if (in_ring[i] == want_linked)
                cands.push_back(4'(i));
        if (cands.size() == 0)
            return 4'($urandom_range(SLOTS - 1));
        return cands[$urandom_range(cands.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty ring, illegal codes, append/remove around the head, walk corners.
    task automatic test_ring_corners();
        send_req(mk_req(REQ_FIND,   4'd0,  32'h0,        1'b0), 0); // empty ring
        send_req(mk_req(REQ_REMOVE, 4'd3,  32'h0,        1'b0), 0); // unlinked
        send_req(mk_req(REQ_NEXT,   4'd3,  32'h0,        1'b0), 0);
        send_req(mk_req(REQ_SETRDY, 4'd3,  32'h0,        1'b1), 0);
        for (int op = REQ_BAD_FIRST; op <= REQ_BAD_LAST; op++)
            send_req(mk_req(3'(op), 4'd15, 32'hFFFF_FFFF, 1'b1), 0);
        send_req(mk_req(REQ_APPEND, 4'd0,  32'h0,        1'b0), 0); // first head
        send_req(mk_req(REQ_APPEND, 4'd15, 32'hFFFF_FFFF, 1'b1), 0);
        send_req(mk_req(REQ_APPEND, 4'd0,  32'h1234_0000, 1'b1), 0); // already linked
        send_req(mk_req(REQ_APPEND, 4'd7,  32'hA5A5_A5A5, 1'b0), 0);
        send_req(mk_req(REQ_NEXT,   4'd0,  32'h0,        1'b0), 0); // skips 7
        send_req(mk_req(REQ_FIND,   4'd0,  32'hFFFF_FFFF, 1'b0), 0);
        send_req(mk_req(REQ_FIND,   4'd0,  32'h1234_5678, 1'b0), 0); // miss
        send_req(mk_req(REQ_SETRDY, 4'd15, 32'h0,        1'b0), 0);
        send_req(mk_req(REQ_NEXT,   4'd7,  32'h0,        1'b0), 0); // nothing ready
        send_req(mk_req(REQ_SETRDY, 4'd7,  32'h0,        1'b1), 0);
        send_req(mk_req(REQ_NEXT,   4'd7,  32'h0,        1'b0), 0); // only start ready
        send_req(mk_req(REQ_REMOVE, 4'd15, 32'h0,        1'b0), 0); // non-head
        send_req(mk_req(REQ_REMOVE, 4'd0,  32'h0,        1'b0), 0); // head advances
        send_req(mk_req(REQ_FIND,   4'd0,  32'h0,        1'b0), 0);
        send_req(mk_req(REQ_REMOVE, 4'd7,  32'h0,        1'b0), 0); // ring empties
        send_req(mk_req(REQ_FIND,   4'd0,  32'hA5A5_A5A5, 1'b0), 0);
        send_req(mk_req(REQ_APPEND, 4'd9,  32'h5A5A_5A5A, 1'b1), 0); // refill
        wait_all_done();
    endtask

    // Mostly well-formed traffic aimed at linked slots and live ids, with the
    // ring size steered between near-empty and full; some noise on top.
    task automatic test_random_traffic(input int count, input int idle_pct);
        t_req r;
        int   nlinked;
        int   sel;
        int   app_w;
        int   rem_w;
        for (int k = 0; k < count; k++) begin
            nlinked = 0;
            for (int i = 0; i < SLOTS; i++)
                nlinked += in_ring[i];
            app_w = (nlinked < 4) ? 40 : (nlinked > 12) ? 8 : 20;
            rem_w = (nlinked > 12) ? 35 : 15;
            r.proc_id  = $urandom;
            r.ready_in = 1'($urandom_range(1));
            sel = $urandom_range(99);
            if (sel < 4) begin
                r.req_type = 3'($urandom_range(REQ_BAD_LAST, REQ_BAD_FIRST));
                r.slot     = 4'($urandom_range(SLOTS - 1));
            end else if (sel < 4 + app_w) begin
                r.req_type = REQ_APPEND;
                r.slot     = pick_slot($urandom_range(99) >= 85);
                // occasional duplicate id so find must return the first one
                if (ring_live && $urandom_range(9) == 0)
                    r.proc_id = owner_id[pick_slot(1'b1)];
            end else begin
                sel = $urandom_range(99);
                if (sel < rem_w)
                    r.req_type = REQ_REMOVE;
                else if (sel < rem_w + 30)
                    r.req_type = REQ_NEXT;
                else if (sel < rem_w + 60)
                    r.req_type = REQ_FIND;
                else
                    r.req_type = REQ_SETRDY;
                r.slot = pick_slot($urandom_range(99) < 85);
                if (r.req_type == REQ_FIND && ring_live && $urandom_range(9) < 7)
                    r.proc_id = owner_id[pick_slot(1'b1)];
            end
            send_req(r, idle_pct);
        end
    endtask

    // Sender holds off mid-stream until the block has returned everything.
    task automatic test_pause_until_drained(input int idle_pct);
        test_random_traffic(200, idle_pct);
        wait_all_done();
        test_random_traffic(150, idle_pct);
        wait_all_done();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ring_corners();
        test_random_traffic(400, 0);    // back-to-back transfers
        wait_all_done();
        test_pause_until_drained(55);   // sender idle about half the time
        test_random_traffic(350, 17);   // light sender gaps
        wait_all_done();
        test_random_traffic(250, 0);
        wait_all_done();

        // catch any stray strobe after the last result
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
